/* rtl/rpa_pkg.sv */
// Shared types and constants of the reference-counted page allocator.
// No dependencies; imported by rpa_ctrl, rpa_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rpa_pkg;

    // Fixed field widths of the ports
    localparam int PAGE_W     = 15;
    localparam int CNT_W      = 16;
    localparam int REF_OUT_W  = 8;
    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DROP  = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'd1;

    // Reset values of the configuration registers
    localparam logic [PAGE_W-1:0] FIRST_PAGE_RST = 15'd0;
    localparam logic [CNT_W-1:0]  PAGE_LIMIT_RST = 16'h8000;

    // Controller to datapath commands
    typedef struct packed {
        logic clr;     // clearing pass: zero one count entry
        logic accept;  // request word taken: launch memory reads
        logic exec;    // read data valid: update state, emit result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;  // clearing pass is at its last entry
    } t_sts;

endpackage

`default_nettype wire

/* rtl/rpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/rpa_ctrl.sv */
// Controller of the page allocator: clearing pass, idle, execute.
// Depends on rpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpa_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           start,
    input  rpa_pkg::t_sts i_sts,
    output logic          busy,
    output rpa_pkg::t_cmd o_cmd
);
    import rpa_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* rtl/rpa_datapath.sv */
// Datapath of the page allocator: free stack, count table, counters, result word.
// Depends on rpa_pkg and rpa_ram.
`timescale 1ns / 1ps
`default_nettype none

module rpa_datapath #(
    parameter int NUM_PAGES = 32768,
    parameter int REF_WIDTH = 8
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  rpa_pkg::t_cmd                      i_cmd,
    output rpa_pkg::t_sts                      o_sts,
    input  wire                                i_cfg_we,
    input  wire [rpa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [rpa_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire [rpa_pkg::REQ_W-1:0]           i_req_type,
    input  wire [rpa_pkg::PAGE_W-1:0]          i_page_index,
    output logic                               o_done,
    output logic [rpa_pkg::STAT_W-1:0]         o_status,
    output logic [rpa_pkg::PAGE_W-1:0]         o_page_out,
    output logic [rpa_pkg::REF_OUT_W-1:0]      o_ref_count,
    output logic [rpa_pkg::CNT_W-1:0]          o_free_count,
    output logic [rpa_pkg::CNT_W-1:0]          o_total_count
);
    import rpa_pkg::*;

    localparam int AW = $clog2(NUM_PAGES);        // table / stack address
    localparam int TW = $clog2(NUM_PAGES + 1);    // stack fill, holds NUM_PAGES
    localparam int PW = (AW > PAGE_W) ? AW : PAGE_W;
    localparam logic [REF_WIDTH-1:0] REF_MAX = {REF_WIDTH{1'b1}};
    localparam logic [REF_WIDTH-1:0] REF_ONE = REF_WIDTH'(1);

    // Configuration
    logic [PAGE_W-1:0] r_first_page;
    logic [CNT_W-1:0]  r_page_limit;

    // Allocator state
    logic [TW-1:0] r_free_top;
    logic [TW-1:0] n_free_top;
    logic [TW-1:0] r_peak;
    logic [TW-1:0] n_peak;
    logic [AW-1:0] r_clr_addr;

    // Request captured at accept
    logic [REQ_W-1:0]  r_req;
    logic [PAGE_W-1:0] r_pg;

    // Memory ports
    logic                 w_ref_we;
    logic [AW-1:0]        w_ref_waddr;
    logic [REF_WIDTH-1:0] w_ref_wdata;
    logic [AW-1:0]        w_ref_raddr;
    logic [REF_WIDTH-1:0] w_ref_rdata;
    logic                 w_stk_we;
    logic [AW-1:0]        w_stk_waddr;
    logic [AW-1:0]        w_stk_raddr;
    logic [PAGE_W-1:0]    w_stk_rdata;

    // Address conversion between page numbers and table addresses
    logic [PW-1:0] w_in_pg_ext;
    logic [PW-1:0] w_pg_ext;
    logic [PW-1:0] w_pop_ext;

    // Execute-cycle decisions
    logic                 w_empty;
    logic                 w_full;
    logic                 w_pg_ok;
    logic                 w_pop_ok;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_upd_we;
    logic [AW-1:0]        w_upd_addr;
    logic [REF_WIDTH-1:0] w_upd_cnt;
    logic [REF_WIDTH-1:0] w_cnt_out;
    logic [STAT_W-1:0]    w_status;
    logic [PAGE_W-1:0]    w_page_out;
    logic [TW-1:0]        w_top_inc;

    assign w_in_pg_ext = PW'(i_page_index);
    assign w_pg_ext    = PW'(r_pg);
    assign w_pop_ext   = PW'(w_stk_rdata);

    assign o_sts.clr_last = (r_clr_addr == AW'(NUM_PAGES - 1));

    // Reads launch in the accept cycle; data is ready in the execute cycle
    assign w_ref_raddr = w_in_pg_ext[AW-1:0];
    assign w_stk_raddr = AW'(r_free_top - TW'(1));

    rpa_ram #(
        .WIDTH (REF_WIDTH),
        .DEPTH (NUM_PAGES)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (w_ref_we),
        .i_waddr (w_ref_waddr),
        .i_wdata (w_ref_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (w_ref_raddr),
        .o_rdata (w_ref_rdata)
    );

    rpa_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (r_pg),
        .i_re    (i_cmd.accept),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    // Request evaluation
    always_comb begin
        w_empty    = (r_free_top == '0);
        w_full     = (r_free_top == TW'(NUM_PAGES));
        w_pg_ok    = (r_pg >= r_first_page) && (CNT_W'(r_pg) < r_page_limit)
                     && (32'(r_pg) < 32'(NUM_PAGES));
        w_pop_ok   = (32'(w_stk_rdata) < 32'(NUM_PAGES));
        w_push     = 1'b0;
        w_pop      = 1'b0;
        w_upd_we   = 1'b0;
        w_upd_addr = w_pg_ext[AW-1:0];
        w_upd_cnt  = '0;
        w_cnt_out  = '0;
        w_status   = ST_OK;
        w_page_out = r_pg;

        if (r_req == REQ_ALLOC) begin
            if (w_empty) begin
                w_status   = ST_NO_FREE;
                w_page_out = '0;
            end else begin
                w_pop      = 1'b1;
                w_page_out = w_stk_rdata;
                w_upd_we   = w_pop_ok;
                w_upd_addr = w_pop_ext[AW-1:0];
                w_upd_cnt  = REF_ONE;
                w_cnt_out  = REF_ONE;
            end
        end else if (!w_pg_ok) begin
            w_status = ST_RANGE;
        end else begin
            case (r_req)
                REQ_ADD: begin
                    if (w_ref_rdata != REF_MAX) begin
                        w_upd_we  = 1'b1;
                        w_upd_cnt = w_ref_rdata + REF_ONE;
                        w_cnt_out = w_ref_rdata + REF_ONE;
                    end else begin
                        w_cnt_out = w_ref_rdata;
                    end
                end
                default: begin
                    // free and drop share the decrement / push path;
                    // drop leaves a zero count alone, free pushes it again
                    if (w_ref_rdata > REF_ONE) begin
                        w_upd_we  = 1'b1;
                        w_upd_cnt = w_ref_rdata - REF_ONE;
                        w_cnt_out = w_ref_rdata - REF_ONE;
                    end else if (r_req == REQ_DROP && w_ref_rdata == '0) begin
                        w_cnt_out = '0;
                    end else if (w_full) begin
                        w_status  = ST_OVERFLOW;
                        w_cnt_out = w_ref_rdata;
                    end else begin
                        w_push    = 1'b1;
                        w_upd_we  = 1'b1;
                        w_upd_cnt = '0;
                        w_cnt_out = '0;
                    end
                end
            endcase
        end
    end

    // Memory write muxing: clearing pass or request update
    always_comb begin
        if (i_cmd.clr) begin
            w_ref_we    = 1'b1;
            w_ref_waddr = r_clr_addr;
            w_ref_wdata = '0;
        end else begin
            w_ref_we    = i_cmd.exec && w_upd_we;
            w_ref_waddr = w_upd_addr;
            w_ref_wdata = w_upd_cnt;
        end
        w_stk_we    = i_cmd.exec && w_push;
        w_stk_waddr = r_free_top[AW-1:0];
    end

    // Stack fill and peak
    always_comb begin
        w_top_inc  = r_free_top + TW'(1);
        n_free_top = r_free_top;
        n_peak     = r_peak;
        if (i_cmd.exec) begin
            if (w_push) begin
                n_free_top = w_top_inc;
                if (w_top_inc > r_peak) begin
                    n_peak = w_top_inc;
                end
            end else if (w_pop) begin
                n_free_top = r_free_top - TW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_page <= FIRST_PAGE_RST;
            r_page_limit <= PAGE_LIMIT_RST;
            r_free_top   <= '0;
            r_peak       <= '0;
            r_clr_addr   <= '0;
            o_done       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FIRST_PAGE: r_first_page <= i_cfg_data[PAGE_W-1:0];
                    CFG_PAGE_LIMIT: r_page_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_free_top <= n_free_top;
            r_peak     <= n_peak;
            o_done     <= i_cmd.exec;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req_type;
            r_pg  <= i_page_index;
        end
        if (i_cmd.exec) begin
            o_status      <= w_status;
            o_page_out    <= w_page_out;
            o_ref_count   <= REF_OUT_W'(w_cnt_out);
            o_free_count  <= CNT_W'(n_free_top);
            o_total_count <= CNT_W'(n_peak);
        end
    end

endmodule

`default_nettype wire

/* rtl/refcounted_page_allocator_unit.sv */
// Top level of the reference-counted page allocator.
// Depends on rpa_pkg, rpa_ctrl, rpa_datapath (and through it rpa_ram).
`timescale 1ns / 1ps
`default_nettype none

// Page allocator with a LIFO free stack and one reference count per page.
// A request word (req_type, page_index) is taken at a clock edge where start
// is high and busy is low. The request then reads the count entry and the
// top stack slot from their synchronous RAMs, and then updates them and the
// counters. The result word is registered in the cycle after the update,
// marked by o_done for exactly one cycle; it cannot be held off, so the
// receiver must take it then. busy is high while a request is in flight, so
// a new request is not taken before the previous one has done its update.
// After reset the count table is zeroed by a clearing pass over all NUM_PAGES
// entries (32768 at the default), one entry per cycle; busy stays high for
// its whole length. Configuration writes (first_page, page_limit) are always
// accepted (o_cfg_ready is tied high) and must only be issued while the block
// is idle. Counts are REF_WIDTH bits wide; o_ref_count shows their low 8 bits.
module refcounted_page_allocator_unit #(
    parameter int NUM_PAGES = 32768,
    parameter int REF_WIDTH = 8
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // request word
    input  wire                                start,
    output logic                               busy,
    input  wire [rpa_pkg::REQ_W-1:0]           i_req_type,
    input  wire [rpa_pkg::PAGE_W-1:0]          i_page_index,
    // result word
    output logic                               o_done,
    output logic [rpa_pkg::STAT_W-1:0]         o_status,
    output logic [rpa_pkg::PAGE_W-1:0]         o_page_out,
    output logic [rpa_pkg::REF_OUT_W-1:0]      o_ref_count,
    output logic [rpa_pkg::CNT_W-1:0]          o_free_count,
    output logic [rpa_pkg::CNT_W-1:0]          o_total_count,
    // configuration write channel
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [rpa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [rpa_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import rpa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // Sequencer: clearing pass, then idle / execute per request
    rpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // Stack, count table, counters and result registers
    rpa_datapath #(
        .NUM_PAGES (NUM_PAGES),
        .REF_WIDTH (REF_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_page_index  (i_page_index),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_page_out    (o_page_out),
        .o_ref_count   (o_ref_count),
        .o_free_count  (o_free_count),
        .o_total_count (o_total_count)
    );

endmodule

`default_nettype wire
